[sv/r2fft_pkg.sv]
// ============================================================================
// r2fft_pkg
// Shared types, constants and the twiddle table for the radix-2 DIF FFT.
// ============================================================================
package r2fft_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int TWIDDLE_BITS = 16;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int DATA_W       = 23;
    localparam int IN_W         = 16;
    localparam int TW_W         = TWIDDLE_BITS + 1;
    localparam int PROD_W       = DATA_W + TW_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int MAX_L        = (ADDR_W > 6) ? 6 : ADDR_W;
    localparam int ENTRY_W      = 2 * DATA_W;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic CFG_INVERSE = 1'b0;
    localparam logic CFG_LOG2    = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BF_READ,
        ST_BF_CALC,
        ST_BF_WRITE,
        ST_OUT_READ,
        ST_OUT_WAIT,
        ST_OUT_SHOW
    } fsm_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              load_we;
        logic [ADDR_W-1:0] load_addr;
        logic              rd_en;
        logic              rd_sel_b;
        logic [ADDR_W-1:0] rd_addr;
        logic              cap_a;
        logic              cap_b;
        logic              calc;
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic [4:0]        tw_index;
        logic              out_load;
        logic              out_last;
    } dp_cmd_t;

    // Quarter-wave cosine table, cos(2*pi*k/64)*2^30
    function automatic logic signed [31:0] cos_raw(input logic [4:0] k);
        logic signed [31:0] v;
        case (k)
            5'd0:    v = 32'sd1073741824;
            5'd1:    v = 32'sd1068571464;
            5'd2:    v = 32'sd1053110176;
            5'd3:    v = 32'sd1027506862;
            5'd4:    v = 32'sd992008094;
            5'd5:    v = 32'sd946955747;
            5'd6:    v = 32'sd892783698;
            5'd7:    v = 32'sd830013654;
            5'd8:    v = 32'sd759250125;
            5'd9:    v = 32'sd681174602;
            5'd10:   v = 32'sd596538995;
            5'd11:   v = 32'sd506158392;
            5'd12:   v = 32'sd410903207;
            5'd13:   v = 32'sd311690800;
            5'd14:   v = 32'sd209476638;
            5'd15:   v = 32'sd105245103;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TW_W-1:0] rom_coef(input logic [4:0] k);
        logic signed [31:0] c;
        logic signed [32:0] r;
        c = cos_raw(k);
        r = {c[31], c} + (33'sd1 <<< (30 - TWIDDLE_BITS));
        r = r >>> (31 - TWIDDLE_BITS);
        return r[TW_W-1:0];
    endfunction

endpackage

[sv/r2fft_ram.sv]
// ============================================================================
// r2fft_ram
// Generic single-port-write, single-read RAM with registered read data.
// ============================================================================
module r2fft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/r2fft_datapath.sv]
// ============================================================================
// r2fft_datapath
// Frame memory, butterfly unit and output register of the FFT.
// ============================================================================
module r2fft_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  r2fft_pkg::dp_cmd_t                cmd,
    input  logic                              inverse_mode,
    input  logic [2:0]                        shift_l,
    input  logic signed [r2fft_pkg::IN_W-1:0] in_real,
    input  logic signed [r2fft_pkg::IN_W-1:0] in_imag,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [r2fft_pkg::DATA_W-1:0] out_real,
    output logic signed [r2fft_pkg::DATA_W-1:0] out_imag,
    output logic                              out_last
);
    import r2fft_pkg::*;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [ENTRY_W-1:0]       wdata;
    logic [ENTRY_W-1:0]       rdata;
    logic [ADDR_W-1:0]        raddr;
    logic signed [DATA_W-1:0] ur_reg, ui_reg, vr_reg, vi_reg;
    logic signed [DATA_W-1:0] sr_reg, si_reg, br_reg, bi_reg;
    logic signed [DATA_W-1:0] dr, di, sr, si;
    logic signed [TW_W-1:0]   wr, wi, cs, sn;
    logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [SUM_W-1:0]  acc_r, acc_i;
    logic signed [DATA_W-1:0] rd_re, rd_im;
    logic                     calc2_reg;

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W:0] v);
        if (v > $signed({1'b0, DATA_MAX}))
        begin
            return DATA_MAX;
        end
        else if (v < $signed({1'b1, DATA_MIN}))
        begin
            return DATA_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] s;
        s = (v + (SUM_W'(1) <<< (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
        if (s > SUM_W'(DATA_MAX))
        begin
            return DATA_MAX;
        end
        else if (s < SUM_W'(DATA_MIN))
        begin
            return DATA_MIN;
        end
        return s[DATA_W-1:0];
    endfunction

    assign raddr = cmd.rd_addr;
    assign rd_re = rdata[DATA_W-1:0];
    assign rd_im = rdata[ENTRY_W-1:DATA_W];

    r2fft_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // twiddle lookup from the quarter-wave table
    always_comb
    begin
        if (cmd.tw_index <= 5'd16)
        begin
            cs = rom_coef(cmd.tw_index);
            sn = rom_coef(5'd16 - cmd.tw_index);
        end
        else
        begin
            cs = -rom_coef(5'd0 - cmd.tw_index);
            sn = rom_coef(cmd.tw_index - 5'd16);
        end
        wr = cs;
        wi = inverse_mode ? sn : -sn;
    end

    // sums, differences and products
    assign sr = sat_add({ur_reg[DATA_W-1], ur_reg} + {vr_reg[DATA_W-1], vr_reg});
    assign si = sat_add({ui_reg[DATA_W-1], ui_reg} + {vi_reg[DATA_W-1], vi_reg});
    assign dr = sat_add({ur_reg[DATA_W-1], ur_reg} - {vr_reg[DATA_W-1], vr_reg});
    assign di = sat_add({ui_reg[DATA_W-1], ui_reg} - {vi_reg[DATA_W-1], vi_reg});
    assign p_rr = PROD_W'(dr) * PROD_W'(wr);
    assign p_ii = PROD_W'(di) * PROD_W'(wi);
    assign p_ri = PROD_W'(dr) * PROD_W'(wi);
    assign p_ir = PROD_W'(di) * PROD_W'(wr);
    assign acc_r = SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg);
    assign acc_i = SUM_W'(p_ri_reg) + SUM_W'(p_ir_reg);

    // operand and product registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            ur_reg <= rd_re;
            ui_reg <= rd_im;
        end
        if (cmd.cap_b)
        begin
            vr_reg <= rd_re;
            vi_reg <= rd_im;
        end
        if (cmd.calc)
        begin
            sr_reg   <= sr;
            si_reg   <= si;
            p_rr_reg <= p_rr;
            p_ii_reg <= p_ii;
            p_ri_reg <= p_ri;
            p_ir_reg <= p_ir;
        end
        if (calc2_reg)
        begin
            br_reg <= sat_wide(acc_r);
            bi_reg <= sat_wide(acc_i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc2_reg <= 1'b0;
        end
        else
        begin
            calc2_reg <= cmd.calc;
        end
    end

    // memory write selection
    always_comb
    begin
        we    = cmd.load_we | cmd.wr_a | cmd.wr_b;
        waddr = cmd.load_we ? cmd.load_addr : cmd.wr_addr;
        if (cmd.load_we)
        begin
            wdata = {DATA_W'(in_imag), DATA_W'(in_real)};
        end
        else if (cmd.wr_a)
        begin
            wdata = {si_reg, sr_reg};
        end
        else
        begin
            wdata = {bi_reg, br_reg};
        end
    end

    // output register with inverse scaling
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_real <= inverse_mode ? (rd_re >>> shift_l) : rd_re;
            out_imag <= inverse_mode ? (rd_im >>> shift_l) : rd_im;
            out_last <= cmd.out_last;
        end
    end

endmodule

[sv/r2fft_ctrl.sv]
// ============================================================================
// r2fft_ctrl
// Sequencer for load, butterfly stages and bit-reversed readout.
// ============================================================================
module r2fft_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         size_l,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    output r2fft_pkg::dp_cmd_t cmd
);
    import r2fft_pkg::*;

    fsm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [2:0]          stage_reg, stage_next;
    logic [ADDR_W-1:0]   a_addr, b_addr, h, rev;
    logic [CNT_W-1:0]    n_pts;
    logic [ADDR_W-1:0]   jj;

    assign n_pts = CNT_W'(1) << size_l;

    // butterfly addresses for pair index cnt in stage s (span 2^(s-1))
    always_comb
    begin
        h      = ADDR_W'(1) << (stage_reg - 3'd1);
        jj     = cnt_reg[ADDR_W-1:0] & (h - ADDR_W'(1));
        a_addr = ((cnt_reg[ADDR_W-1:0] & ~(h - ADDR_W'(1))) << 1) | jj;
        b_addr = a_addr | h;
        rev    = '0;
        for (int q = 0; q < ADDR_W; q++)
        begin
            if (q < int'(size_l))
            begin
                rev[int'(size_l) - 1 - q] = cnt_reg[q];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stage_reg <= stage_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        stage_next   = stage_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.load_addr = cnt_reg[ADDR_W-1:0];
        cmd.tw_index = 5'(jj << (3'd6 - stage_reg));
        cmd.wr_addr  = a_addr;
        unique case (state_reg)
            ST_LOAD:
            begin
                // no sample transfer in the cycle of a register write
                in_ready = !cfg_write;
                if (cfg_write)
                begin
                    cnt_next = '0;
                end
                else if (in_valid)
                begin
                    cmd.load_we = 1'b1;
                    if (cnt_reg + CNT_W'(1) == n_pts)
                    begin
                        cnt_next   = '0;
                        stage_next = size_l;
                        state_next = ST_BF_READ;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_BF_READ:
            begin
                // two reads: a then b, each captured in the cycle after its read
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = a_addr;
                state_next  = ST_BF_CALC;
            end
            ST_BF_CALC:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = b_addr;
                cmd.cap_a   = 1'b1;
                state_next  = ST_BF_WRITE;
                stage_next  = stage_reg;
            end
            ST_BF_WRITE:
            begin
                // capture the b operand from the second read
                cmd.cap_b  = 1'b1;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (!cmd.rd_sel_b && stage_reg != 3'd0)
                begin
                    cmd.calc   = 1'b1;
                    state_next = ST_OUT_SHOW;
                end
                else
                begin
                    if (out_valid && !out_ready)
                    begin
                        state_next = ST_OUT_WAIT;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = (cnt_reg + CNT_W'(1) == n_pts);
                        if (cnt_reg + CNT_W'(1) == n_pts)
                        begin
                            cnt_next   = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + CNT_W'(1);
                            state_next = ST_OUT_READ;
                        end
                    end
                end
            end
            ST_OUT_SHOW:
            begin
                // product register is filled now; write a, then b next cycle
                if (!cmd.rd_sel_b)
                begin
                    cmd.wr_a    = 1'b1;
                    cmd.wr_addr = a_addr;
                    state_next  = ST_OUT_READ;
                end
            end
            ST_OUT_READ:
            begin
                if (stage_reg != 3'd0)
                begin
                    cmd.wr_b    = 1'b1;
                    cmd.wr_addr = b_addr;
                    if (cnt_reg + CNT_W'(1) == (n_pts >> 1))
                    begin
                        cnt_next   = '0;
                        stage_next = stage_reg - 3'd1;
                        state_next = (stage_reg == 3'd1) ? ST_OUT_READ : ST_BF_READ;
                        if (stage_reg == 3'd1)
                        begin
                            cmd.rd_en   = 1'b0;
                        end
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = ST_BF_READ;
                    end
                end
                else
                begin
                    // readout: fetch bin cnt from its bit-reversed address
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel_b = 1'b1;
                    cmd.rd_addr  = rev;
                    state_next   = ST_OUT_WAIT;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (state_reg == ST_OUT_WAIT && stage_reg == 3'd0)
        begin
            cmd.rd_sel_b = 1'b1;
        end
    end

endmodule

[sv/radix2_dif_fft_ifft.sv]
// ============================================================================
// radix2_dif_fft_ifft
// Radix-2 decimation-in-frequency FFT/IFFT over frames of up to 64 points.
// ============================================================================
// Usage:
//   s_axis_* carries input samples, tdata = {sample_imag, sample_real}.
//   m_axis_* carries bins in natural order, tdata = {result_imag, result_real},
//   tlast marks bin N-1. The cfg_* port writes inverse_mode (0) and
//   log2_points (1); a write during loading restarts frame loading.
// Operation:
//   Loading takes one sample per cycle while no cfg_* write is made. Each
//   butterfly runs on the single memory port as two reads, a two-stage
//   multiply and two writes. Readout fetches each bin through the registered
//   memory read. No sample is taken during transform or readout.
// Reset:
//   Returns to loading with an empty frame, forward mode, 64 points.
// Stall:
//   When m_axis_tready is low the output register holds and the readout
//   sequencer waits.
// ============================================================================
module radix2_dif_fft_ifft (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] sample_real, [31:16] sample_imag
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [22:0] result_real, [45:23] result_imag
    output logic        m_axis_tlast
);
    import r2fft_pkg::*;

    logic        inverse_reg;
    logic [2:0]  log2_reg;
    logic [2:0]  size_l;
    dp_cmd_t     cmd;
    logic signed [DATA_W-1:0] o_re, o_im;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= 1'b0;
            log2_reg    <= 3'd6;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_INVERSE)
            begin
                inverse_reg <= cfg_wdata[0];
            end
            else
            begin
                log2_reg <= cfg_wdata;
            end
        end
    end

    // clamp size exponent
    always_comb
    begin
        if (log2_reg == 3'd0)
        begin
            size_l = 3'd1;
        end
        else if (log2_reg > 3'(MAX_L))
        begin
            size_l = 3'(MAX_L);
        end
        else
        begin
            size_l = log2_reg;
        end
    end

    r2fft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_we),
        .size_l    (size_l),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    r2fft_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .inverse_mode (inverse_reg),
        .shift_l      (size_l),
        .in_real      (s_axis_tdata[15:0]),
        .in_imag      (s_axis_tdata[31:16]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_real     (o_re),
        .out_imag     (o_im),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, o_im, o_re};

`ifndef NO_ASSERTIONS
    // a new bin never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !cmd.out_load)
        else $error("output overwritten while stalled");

    // loading and butterfly writes never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_we |-> !(cmd.wr_a || cmd.wr_b))
        else $error("load collides with butterfly write");

    // inputs are only taken while idle of results
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !cmd.out_load)
        else $error("input ready during readout");
`endif

endmodule
